// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AKE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AKE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/aes256ke_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes256ke_pkg
// Types, sizes and tables for the AES-256 key expansion block.
// ----------------------------------------------------------------------------
package aes256ke_pkg;

  localparam int KEY_PART_W = 64;
  localparam int WORD_W     = 32;
  localparam int INDEX_W    = 6;
  localparam int KEY_WORDS  = 8;

  localparam logic [INDEX_W-1:0] LAST_INDEX = 6'd59;
  localparam logic [2:0]         PHASE_ROT  = 3'd0;
  localparam logic [2:0]         PHASE_SUB  = 3'd4;

  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [INDEX_W-1:0]    index_t;
  typedef logic [KEY_PART_W-1:0] key_part_t;

  // Control for one next-word computation.
  typedef struct packed {
    logic       rot;
    logic       sub;
    logic [2:0] rcon_sel;
  } nw_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rcon_lookup(input logic [2:0] sel);
    logic [7:0] r;
    case (sel)
      3'd1:    r = 8'h01;
      3'd2:    r = 8'h02;
      3'd3:    r = 8'h04;
      3'd4:    r = 8'h08;
      3'd5:    r = 8'h10;
      3'd6:    r = 8'h20;
      3'd7:    r = 8'h40;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/aes256ke_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes256ke_ifs
// Valid/ready channels: the key channel and the round-key word channel.
// ----------------------------------------------------------------------------
interface aes256ke_key_if
  import aes256ke_pkg::*;
  ();
  logic      valid;
  logic      ready;
  key_part_t key_part_0;
  key_part_t key_part_1;
  key_part_t key_part_2;
  key_part_t key_part_3;

  modport source (output valid, key_part_0, key_part_1, key_part_2, key_part_3,
                  input ready);
  modport sink   (input valid, key_part_0, key_part_1, key_part_2, key_part_3,
                  output ready);
endinterface

interface aes256ke_word_if
  import aes256ke_pkg::*;
  ();
  logic   valid;
  logic   ready;
  index_t word_index;
  word_t  round_key_word;
  logic   last_word;

  modport source (output valid, word_index, round_key_word, last_word, input ready);
  modport sink   (input valid, word_index, round_key_word, last_word, output ready);
endinterface
`default_nettype wire

// ===== hdl/aes256ke_next_word.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes256ke_next_word
// One key-schedule step: w[i] = w[i-8] ^ f(w[i-1]).
// ----------------------------------------------------------------------------
module aes256ke_next_word
  import aes256ke_pkg::*;
(
  input  wire word_t   old_word,
  input  wire word_t   prev_word,
  input  wire nw_ctl_t ctl,
  output word_t        new_word
);

  word_t rot_w;
  word_t sub_w;
  word_t t_w;

  always_comb begin
    rot_w = ctl.rot ? {prev_word[23:0], prev_word[31:24]} : prev_word;
    sub_w = {SBOX[rot_w[31:24]], SBOX[rot_w[23:16]], SBOX[rot_w[15:8]], SBOX[rot_w[7:0]]};
    if (ctl.rot) begin
      t_w = sub_w ^ {rcon_lookup(ctl.rcon_sel), 24'h000000};
    end else if (ctl.sub) begin
      t_w = sub_w;
    end else begin
      t_w = prev_word;
    end
    new_word = old_word ^ t_w;
  end

endmodule
`default_nettype wire

// ===== hdl/aes256_key_expansion_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes256_key_expansion_top
// AES-256 key expansion from a word shift line: one round-key word per cycle while unstalled.
//
// in_ch  : one 256-bit key per transfer, as four 64-bit parts. Ready is high
//          only while no key is being expanded.
// out_ch : 60 round-key words per key, index 0..59, last_word on index 59.
// The key sits in an eight-word shift line; each step emits the oldest word
// and shifts in w[i+8], computed from the oldest and newest entries through
// one four-byte S-box path. The first word is registered into the output
// register by the first step after the key is loaded. Each key takes a load
// step and 60 steps through the single next-word unit.
// A stalled receiver holds the output register and freezes the shift line;
// no word is lost. The next key is taken while the last word still waits.
// Reset (rst_n low, synchronous) drops any key in progress and clears the
// output valid.
// ----------------------------------------------------------------------------
module aes256_key_expansion_top
  import aes256ke_pkg::*;
(
  input  wire           clk,
  input  wire           rst_n,
  aes256ke_key_if.sink  in_ch,
  aes256ke_word_if.source out_ch
);

  logic [KEY_WORDS-1:0][WORD_W-1:0] win_r, win_nxt;
  index_t  cnt_r, cnt_nxt;
  logic    busy_r, busy_nxt;
  logic    out_valid_r, out_valid_nxt;
  index_t  out_index_r, out_index_nxt;
  word_t   out_word_r, out_word_nxt;
  logic    out_last_r, out_last_nxt;

  logic    in_acc;
  logic    step;
  nw_ctl_t nw_ctl;
  word_t   new_word;

  assign in_ch.ready = !busy_r;
  assign in_acc      = in_ch.valid && !busy_r;
  assign step        = busy_r && (!out_valid_r || out_ch.ready);

  assign nw_ctl.rot      = (cnt_r[2:0] == PHASE_ROT);
  assign nw_ctl.sub      = (cnt_r[2:0] == PHASE_SUB);
  assign nw_ctl.rcon_sel = cnt_r[5:3] + 3'd1;

  aes256ke_next_word u_next_word (
    .old_word  (win_r[0]),
    .prev_word (win_r[KEY_WORDS-1]),
    .ctl       (nw_ctl),
    .new_word  (new_word)
  );

  always_comb begin
    win_nxt       = win_r;
    cnt_nxt       = cnt_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_index_nxt = out_index_r;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      win_nxt[0] = in_ch.key_part_0[63:32];
      win_nxt[1] = in_ch.key_part_0[31:0];
      win_nxt[2] = in_ch.key_part_1[63:32];
      win_nxt[3] = in_ch.key_part_1[31:0];
      win_nxt[4] = in_ch.key_part_2[63:32];
      win_nxt[5] = in_ch.key_part_2[31:0];
      win_nxt[6] = in_ch.key_part_3[63:32];
      win_nxt[7] = in_ch.key_part_3[31:0];
      cnt_nxt    = '0;
      busy_nxt   = 1'b1;
    end else if (step) begin
      for (int k = 0; k < KEY_WORDS - 1; k++) begin
        win_nxt[k] = win_r[k+1];
      end
      win_nxt[KEY_WORDS-1] = new_word;
      out_valid_nxt = 1'b1;
      out_index_nxt = cnt_r;
      out_word_nxt  = win_r[0];
      out_last_nxt  = (cnt_r == LAST_INDEX);
      cnt_nxt       = cnt_r + 6'd1;
      if (cnt_r == LAST_INDEX) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r       <= win_nxt;
    out_index_r <= out_index_nxt;
    out_word_r  <= out_word_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.word_index     = out_index_r;
  assign out_ch.round_key_word = out_word_r;
  assign out_ch.last_word      = out_last_r;

endmodule
`default_nettype wire

// ===== hdl/aes256ke_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes256ke_checker
// Port-level checks on the key expansion block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aes256ke_checker
  import aes256ke_pkg::*;
(
  input wire         clk,
  input wire         rst_n,
  input wire         in_valid,
  input wire         in_ready,
  input wire         out_valid,
  input wire         out_ready,
  input wire index_t out_word_index,
  input wire word_t  out_round_key_word,
  input wire         out_last_word
);

  `AKE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word_index) && $stable(out_round_key_word))
  `AKE_ASSERT_IMP(a_last_flag, clk, rst_n, out_valid, out_last_word == (out_word_index == LAST_INDEX))
  `AKE_ASSERT_NXT(a_busy_after_key, clk, rst_n, in_valid && in_ready, !in_ready)
  `AKE_ASSERT_IMP(a_index_range, clk, rst_n, out_valid, out_word_index <= LAST_INDEX)

endmodule

bind aes256_key_expansion_top aes256ke_checker u_aes256ke_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_word_index     (out_ch.word_index),
  .out_round_key_word (out_ch.round_key_word),
  .out_last_word      (out_ch.last_word)
);
`default_nettype wire
